FILE: design/rne_pkg.sv
`timescale 1ns / 1ps
package rne_pkg;

	localparam logic [6:0] CH_I = 7'h49;
	localparam logic [6:0] CH_V = 7'h56;
	localparam logic [6:0] CH_X = 7'h58;
	localparam logic [6:0] CH_L = 7'h4C;
	localparam logic [6:0] CH_C = 7'h43;
	localparam logic [6:0] CH_D = 7'h44;
	localparam logic [6:0] CH_M = 7'h4D;
	localparam logic [6:0] CH_NONE = 7'h00;

	localparam int unsigned SLOTS = 16;

	typedef struct packed {
		logic [2:0] th;
		logic [3:0] hu;
		logic [3:0] te;
		logic [3:0] on;
	} digits_t;

	typedef struct packed {
		logic [3:0][6:0] letters;
		logic [3:0]      mask;
	} group_t;

	typedef struct packed {
		logic [SLOTS-1:0][6:0] letters;
		logic [SLOTS-1:0]      mask;
	} spell_t;

	function automatic group_t spell_digit(input logic [3:0] d, input logic [6:0] one,
			input logic [6:0] five, input logic [6:0] ten);
		group_t g;
		g.letters = {one, one, one, one};
		g.mask    = 4'b0000;
		case (d)
			4'd1: begin
				g.mask = 4'b0001;
			end
			4'd2: begin
				g.mask = 4'b0011;
			end
			4'd3: begin
				g.mask = 4'b0111;
			end
			4'd4: begin
				g.letters[1] = five;
				g.mask = 4'b0011;
			end
			4'd5: begin
				g.letters[0] = five;
				g.mask = 4'b0001;
			end
			4'd6: begin
				g.letters[0] = five;
				g.mask = 4'b0011;
			end
			4'd7: begin
				g.letters[0] = five;
				g.mask = 4'b0111;
			end
			4'd8: begin
				g.letters[0] = five;
				g.mask = 4'b1111;
			end
			4'd9: begin
				g.letters[1] = ten;
				g.mask = 4'b0011;
			end
			default: begin
				g.mask = 4'b0000;
			end
		endcase
		return g;
	endfunction

	function automatic group_t spell_thousands(input logic [2:0] th);
		group_t g;
		g.letters = {CH_M, CH_M, CH_M, CH_M};
		case (th)
			3'd1: g.mask = 4'b0001;
			3'd2: g.mask = 4'b0011;
			3'd3: g.mask = 4'b0111;
			3'd4: g.mask = 4'b1111;
			default: g.mask = 4'b0000;
		endcase
		return g;
	endfunction

endpackage

FILE: design/rne_digits.sv
`timescale 1ns / 1ps
module rne_digits
	import rne_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [11:0] value,
	output logic       out_valid,
	input  logic       out_stall,
	output digits_t    digits
);

	logic       v_s1, v_s2, v_s3;
	logic       en1, en2, en3;
	logic [2:0] th_s1, th_s2;
	logic [9:0] rem_s1;
	logic [3:0] hu_s2;
	logic [6:0] rem_s2;
	digits_t    dig_s3;

	logic [2:0]  th_c;
	logic [11:0] rem_c;
	logic [15:0] hu_prod;
	logic [3:0]  hu_c;
	logic [10:0] hu_back;
	logic [9:0]  rem2_c;
	logic [14:0] te_prod;
	logic [3:0]  te_c;
	logic [7:0]  te_back;
	logic [6:0]  on_c;

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_comb begin
		if (value >= 12'd4000) begin
			th_c  = 3'd4;
			rem_c = value - 12'd4000;
		end else if (value >= 12'd3000) begin
			th_c  = 3'd3;
			rem_c = value - 12'd3000;
		end else if (value >= 12'd2000) begin
			th_c  = 3'd2;
			rem_c = value - 12'd2000;
		end else if (value >= 12'd1000) begin
			th_c  = 3'd1;
			rem_c = value - 12'd1000;
		end else begin
			th_c  = 3'd0;
			rem_c = value;
		end
	end

	assign hu_prod = 16'(rem_s1) * 16'd41;
	assign hu_c    = hu_prod[15:12];
	assign hu_back = 11'(hu_c) * 11'd100;
	assign rem2_c  = rem_s1 - hu_back[9:0];

	assign te_prod = 15'(rem_s2) * 15'd205;
	assign te_c    = te_prod[14:11];
	assign te_back = 8'(te_c) * 8'd10;
	assign on_c    = rem_s2 - te_back[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			th_s1  <= th_c;
			rem_s1 <= rem_c[9:0];
		end
		if (en2 && v_s1) begin
			th_s2  <= th_s1;
			hu_s2  <= hu_c;
			rem_s2 <= rem2_c[6:0];
		end
		if (en3 && v_s2) begin
			dig_s3.th <= th_s2;
			dig_s3.hu <= hu_s2;
			dig_s3.te <= te_c;
			dig_s3.on <= on_c[3:0];
		end
	end

	assign out_valid = v_s3;
	assign digits    = dig_s3;

endmodule

FILE: design/rne_expand.sv
`timescale 1ns / 1ps
module rne_expand
	import rne_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  digits_t digits,
	output logic    out_valid,
	input  logic    out_stall,
	output spell_t  spell
);

	logic   v_s4;
	logic   en4;
	spell_t spell_s4;
	group_t g_th, g_hu, g_te, g_on;

	assign en4      = !v_s4 || !out_stall;
	assign in_stall = !en4;

	assign g_th = spell_thousands(digits.th);
	assign g_hu = spell_digit(digits.hu, CH_C, CH_D, CH_M);
	assign g_te = spell_digit(digits.te, CH_X, CH_L, CH_C);
	assign g_on = spell_digit(digits.on, CH_I, CH_V, CH_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			spell_s4.letters <= {g_on.letters, g_te.letters, g_hu.letters, g_th.letters};
			spell_s4.mask    <= {g_on.mask, g_te.mask, g_hu.mask, g_th.mask};
		end
	end

	assign out_valid = v_s4;
	assign spell     = spell_s4;

endmodule

FILE: design/rne_serial.sv
`timescale 1ns / 1ps
module rne_serial
	import rne_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  spell_t     spell,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [6:0] symbol,
	output logic       empty_res,
	output logic       last
);

	logic                  busy_q;
	logic                  zero_q;
	logic [SLOTS-1:0][6:0] letters_q;
	logic [SLOTS-1:0]      rem_q;
	logic                  out_valid_q;
	logic [6:0]            symbol_q;
	logic                  empty_q;
	logic                  last_q;

	logic                  load_out;
	logic                  emit;
	logic                  done;
	logic                  take;
	logic [SLOTS-1:0]      next_rem;
	logic [3:0]            idx;

	always_comb begin
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) idx = 4'(i);
		end
	end

	assign next_rem = rem_q & (rem_q - 1'b1);
	assign load_out = !out_valid_q || !res_stall;
	assign emit     = busy_q && load_out;
	assign done     = emit && (zero_q || next_rem == '0);
	assign in_stall = busy_q && !done;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (load_out) out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			letters_q <= spell.letters;
			rem_q     <= spell.mask;
			zero_q    <= (spell.mask == '0);
		end else if (emit) begin
			rem_q <= next_rem;
		end
		if (emit) begin
			symbol_q <= zero_q ? CH_NONE : letters_q[idx];
			empty_q  <= zero_q;
			last_q   <= zero_q || (next_rem == '0);
		end
	end

	assign res_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign empty_res = empty_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && empty_q |-> last_q)
		else $error("empty request not marked last");

	a_busy_has_letters: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !zero_q |-> rem_q != '0)
		else $error("serialiser busy with no letters left");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_valid_q && res_stall |=> $stable(rem_q) && busy_q)
		else $error("letters advanced while output stalled");

	a_no_take_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_valid_q && res_stall |-> in_stall)
		else $error("request taken while serialiser held");
`endif

endmodule

FILE: design/roman_numeral_encoder.sv
`timescale 1ns / 1ps
// Converts a 12-bit binary number to its Roman numeral and sends the letters out as
// ASCII codes, one per cycle while res_stall is low, most significant first, with
// last on the final letter. Zero gives a single result with empty_res and last set
// and symbol zero; 4000 and above are written with four M letters. A request passes
// four pipeline stages (digit split, hundreds, tens/ones, letter expansion) and then
// the serialiser. A request gives 1 to 15 results on the single character output
// (3888 is the longest numeral), and the next request's first letter follows the
// previous last one with no gap when that request is already waiting.
module roman_numeral_encoder
	import rne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [11:0] value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [6:0]  symbol,
	output logic        empty_res,
	output logic        last
);

	logic    dig_valid, dig_stall;
	digits_t digits;
	logic    sp_valid, sp_stall;
	spell_t  spell;

	rne_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_stall  (req_stall),
		.value     (value),
		.out_valid (dig_valid),
		.out_stall (dig_stall),
		.digits    (digits)
	);

	rne_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dig_valid),
		.in_stall  (dig_stall),
		.digits    (digits),
		.out_valid (sp_valid),
		.out_stall (sp_stall),
		.spell     (spell)
	);

	rne_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sp_valid),
		.in_stall  (sp_stall),
		.spell     (spell),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.symbol    (symbol),
		.empty_res (empty_res),
		.last      (last)
	);

endmodule
